[rtl/msc_pkg.sv]
// Shared types and constants for the mark-and-sweep collector.
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

    // Default sizing handed to the top level
    localparam int NODE_COUNT_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 8;

    // Outgoing edge slots per node
    localparam int EDGE_SLOTS = 3;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_EDGE    = 2'd1,
        CMD_XREF    = 2'd2,
        CMD_COLLECT = 2'd3
    } t_cmd;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT,
        ST_POP,
        ST_FETCH,
        ST_SLOT,
        ST_SCAN,
        ST_DEC,
        ST_PEEK,
        ST_EMIT,
        ST_FIN
    } t_state;

    // Reference count read-modify-write operations
    typedef enum logic [2:0] {
        COP_NONE,
        COP_INC,
        COP_DEC,
        COP_ZERO,
        COP_PEEK
    } t_cop;

    // One result beat
    typedef struct packed {
        logic               freed_valid;
        logic [2:0]         freed_index;
        logic signed [31:0] freed_value;
        logic [7:0]         freed_count;
        logic               last;
    } t_result;

    localparam t_result RES_EMPTY = '{1'b0, 3'd0, 32'sd0, 8'd0, 1'b1};

endpackage

`default_nettype wire

[rtl/msc_if.sv]
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none

interface msc_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [2:0]         node_index;
    logic signed [31:0] node_value;
    logic [1:0]         edge_slot;
    logic [2:0]         target_index;

    modport source (
        output valid, command, node_index, node_value, edge_slot, target_index,
        input  ready
    );
    modport sink (
        input  valid, command, node_index, node_value, edge_slot, target_index,
        output ready
    );
endinterface

interface msc_res_if;
    logic               valid;
    logic               ready;
    logic               freed_valid;
    logic [2:0]         freed_index;
    logic signed [31:0] freed_value;
    logic [7:0]         freed_count;
    logic               last;

    modport source (
        output valid, freed_valid, freed_index, freed_value, freed_count, last,
        input  ready
    );
    modport sink (
        input  valid, freed_valid, freed_index, freed_value, freed_count, last,
        output ready
    );
endinterface

`default_nettype wire

[rtl/mark_sweep_collector.sv]
// Top level of the mark-and-sweep collector: node pool memories and controller.
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  i_cmd   | in  | command, node_index, node_value, edge_slot, target_index
//  o_res   | out | freed_valid, freed_index, freed_value, freed_count, last
//
// Load, set edge and external reference take one beat per cycle while idle; the
// count update is a registered read-modify-write with forwarding from the last write.
// Collect marks by pushing the root, then per marked node a stack pop, an edge fetch
// and one slot per cycle; the sweep then scans each node and per freed node does three
// count decrements, a count read and a result, then closes; output stalls hold it.
// Reset clears control state only; node memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mark_sweep_collector
    import msc_pkg::*;
#(
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    msc_cmd_if.sink    i_cmd,
    msc_res_if.source  o_res
);

    localparam int IW  = $clog2(NODE_COUNT);
    localparam int XW  = (IW > 3) ? IW : 3;
    localparam int SPW = IW + 1;
    localparam int EW  = IW + 1;
    localparam int CW  = COUNT_WIDTH;
    localparam int XC  = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] CNT_MAX   = '1;
    localparam logic [IW-1:0] LAST_NODE = IW'(NODE_COUNT - 1);
    localparam logic [1:0]    SLOT_LAST = 2'(EDGE_SLOTS - 1);

    // Registers
    t_state                r_state, n_state;
    logic [NODE_COUNT-1:0] r_live, n_live;
    logic [NODE_COUNT-1:0] r_mark, n_mark;
    logic [SPW-1:0]        r_sp, n_sp;
    logic [IW-1:0]         r_n, n_n;
    logic                  r_root_ok, n_root_ok;
    logic [1:0]            r_slot, n_slot;
    t_cop                  r_cop, n_cop;
    logic [IW-1:0]         r_caddr, n_caddr;
    logic                  r_fwd_vld;
    logic [IW-1:0]         r_fwd_addr;
    logic [CW-1:0]         r_fwd_data;
    t_result               r_pend, n_pend;
    logic                  r_pend_vld, n_pend_vld;
    t_result               r_out, n_out;
    logic                  r_out_vld, n_out_vld;

    // Memory ports
    logic                  c_val_we, c_val_re;
    logic [IW-1:0]         c_val_waddr, c_val_raddr;
    logic signed [31:0]    c_val_wdata;
    logic [31:0]           c_val_rdata;
    logic [EDGE_SLOTS-1:0] c_edge_we;
    logic                  c_edge_re;
    logic [IW-1:0]         c_edge_waddr, c_edge_raddr;
    logic [EW-1:0]         c_edge_wdata;
    logic [EW-1:0]         c_edge_rdata [EDGE_SLOTS];
    logic                  c_cnt_we;
    logic [CW-1:0]         c_cnt_wdata, c_cnt_rdata, c_cnt_cur;
    logic                  c_stk_we, c_stk_re;
    logic [IW-1:0]         c_stk_waddr, c_stk_raddr, c_stk_wdata, c_stk_rdata;

    // Decoded inputs and helpers
    logic                  c_acc;
    logic [XW-1:0]         c_idx_x, c_tgt_x, c_n_x;
    logic [IW-1:0]         c_idx, c_tgt;
    logic                  c_idx_ok, c_tgt_ok;
    logic [EW-1:0]         c_edge_sel;
    logic                  c_sel_pres;
    logic [IW-1:0]         c_sel_tgt;
    logic                  c_node_free;
    logic                  c_out_free;
    logic                  c_emit_go;
    logic [SPW-1:0]        c_sp_dec;
    logic [XC-1:0]         c_cnt_x;

    // Memories
    msc_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (c_val_we),
        .i_waddr(c_val_waddr),
        .i_wdata(c_val_wdata),
        .i_re   (c_val_re),
        .i_raddr(c_val_raddr),
        .o_rdata(c_val_rdata)
    );

    for (genvar s = 0; s < EDGE_SLOTS; s++) begin : g_edge
        msc_ram #(.WIDTH(EW), .DEPTH(NODE_COUNT)) u_edge_ram (
            .i_clk  (i_clk),
            .i_we   (c_edge_we[s]),
            .i_waddr(c_edge_waddr),
            .i_wdata(c_edge_wdata),
            .i_re   (c_edge_re),
            .i_raddr(c_edge_raddr),
            .o_rdata(c_edge_rdata[s])
        );
    end

    msc_ram #(.WIDTH(CW), .DEPTH(NODE_COUNT)) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (c_cnt_we),
        .i_waddr(r_caddr),
        .i_wdata(c_cnt_wdata),
        .i_re   (1'b1),
        .i_raddr(n_caddr),
        .o_rdata(c_cnt_rdata)
    );

    msc_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_stk_ram (
        .i_clk  (i_clk),
        .i_we   (c_stk_we),
        .i_waddr(c_stk_waddr),
        .i_wdata(c_stk_wdata),
        .i_re   (c_stk_re),
        .i_raddr(c_stk_raddr),
        .o_rdata(c_stk_rdata)
    );

    // Input decode
    assign c_acc    = i_cmd.valid && i_cmd.ready;
    assign c_idx_x  = XW'(i_cmd.node_index);
    assign c_tgt_x  = XW'(i_cmd.target_index);
    assign c_idx    = c_idx_x[IW-1:0];
    assign c_tgt    = c_tgt_x[IW-1:0];
    assign c_idx_ok = (32'(i_cmd.node_index) < NODE_COUNT);
    assign c_tgt_ok = (32'(i_cmd.target_index) < NODE_COUNT);

    // Edge slot selected by the slot counter
    always_comb begin
        case (r_slot)
            2'd0:    c_edge_sel = c_edge_rdata[0];
            2'd1:    c_edge_sel = c_edge_rdata[1];
            2'd2:    c_edge_sel = c_edge_rdata[2];
            default: c_edge_sel = '0;
        endcase
    end
    assign c_sel_pres = c_edge_sel[EW-1];
    assign c_sel_tgt  = c_edge_sel[IW-1:0];

    assign c_node_free = r_live[r_n] && !r_mark[r_n];
    assign c_out_free  = !r_out_vld || o_res.ready;
    assign c_emit_go   = !r_pend_vld || c_out_free;
    assign c_sp_dec    = r_sp - SPW'(1);
    assign c_n_x       = XW'(r_n);

    // Count read-modify-write, forwarding the write of the previous cycle
    assign c_cnt_cur = (r_fwd_vld && (r_fwd_addr == r_caddr)) ? r_fwd_data : c_cnt_rdata;
    assign c_cnt_x   = XC'(c_cnt_cur);

    always_comb begin
        c_cnt_we    = 1'b0;
        c_cnt_wdata = c_cnt_cur;
        case (r_cop)
            COP_INC: begin
                c_cnt_we    = 1'b1;
                c_cnt_wdata = (c_cnt_cur == CNT_MAX) ? c_cnt_cur : c_cnt_cur + CW'(1);
            end
            COP_DEC: begin
                c_cnt_we    = 1'b1;
                c_cnt_wdata = (c_cnt_cur == '0) ? c_cnt_cur : c_cnt_cur - CW'(1);
            end
            COP_ZERO: begin
                c_cnt_we    = 1'b1;
                c_cnt_wdata = '0;
            end
            default: begin
                c_cnt_we    = 1'b0;
                c_cnt_wdata = c_cnt_cur;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (c_acc && (t_cmd'(i_cmd.command) == CMD_COLLECT)) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT:  n_state = ST_POP;
            ST_POP:   n_state = (r_sp == '0) ? ST_SCAN : ST_FETCH;
            ST_FETCH: n_state = ST_SLOT;
            ST_SLOT: begin
                if (r_slot == SLOT_LAST) begin
                    n_state = ST_POP;
                end
            end
            ST_SCAN: begin
                if (c_node_free) begin
                    n_state = ST_DEC;
                end else if (r_n == LAST_NODE) begin
                    n_state = ST_FIN;
                end
            end
            ST_DEC: begin
                if (r_slot == SLOT_LAST) begin
                    n_state = ST_PEEK;
                end
            end
            ST_PEEK: n_state = ST_EMIT;
            ST_EMIT: begin
                if (c_emit_go) begin
                    n_state = (r_n == LAST_NODE) ? ST_FIN : ST_SCAN;
                end
            end
            ST_FIN: begin
                if (c_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_live       = r_live;
        n_mark       = r_mark;
        n_sp         = r_sp;
        n_n          = r_n;
        n_root_ok    = r_root_ok;
        n_slot       = r_slot;
        n_cop        = COP_NONE;
        n_caddr      = r_caddr;
        n_pend       = r_pend;
        n_pend_vld   = r_pend_vld;
        n_out        = r_out;
        n_out_vld    = r_out_vld && !o_res.ready;
        c_val_we     = 1'b0;
        c_val_waddr  = c_idx;
        c_val_wdata  = i_cmd.node_value;
        c_val_re     = 1'b0;
        c_val_raddr  = r_n;
        c_edge_we    = '0;
        c_edge_waddr = c_idx;
        c_edge_wdata = '0;
        c_edge_re    = 1'b0;
        c_edge_raddr = r_n;
        c_stk_we     = 1'b0;
        c_stk_waddr  = r_sp[IW-1:0];
        c_stk_wdata  = c_sel_tgt;
        c_stk_re     = 1'b0;
        c_stk_raddr  = c_sp_dec[IW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (c_acc) begin
                    case (t_cmd'(i_cmd.command))
                        CMD_LOAD: begin
                            if (c_idx_ok) begin
                                c_val_we       = 1'b1;
                                c_edge_we      = '1;
                                c_edge_wdata   = '0;
                                n_live[c_idx]  = 1'b1;
                                n_mark[c_idx]  = 1'b0;
                                n_cop          = COP_ZERO;
                                n_caddr        = c_idx;
                            end
                        end
                        CMD_EDGE: begin
                            if (c_idx_ok && c_tgt_ok && r_live[c_idx] && r_live[c_tgt]) begin
                                for (int s = 0; s < EDGE_SLOTS; s++) begin
                                    if (i_cmd.edge_slot == 2'(s)) begin
                                        c_edge_we[s] = 1'b1;
                                    end
                                end
                                c_edge_wdata = {1'b1, c_tgt};
                                if (i_cmd.edge_slot <= SLOT_LAST) begin
                                    n_cop   = COP_INC;
                                    n_caddr = c_tgt;
                                end
                            end
                        end
                        CMD_XREF: begin
                            if (c_idx_ok && r_live[c_idx]) begin
                                n_cop   = COP_INC;
                                n_caddr = c_idx;
                            end
                        end
                        CMD_COLLECT: begin
                            n_n       = c_idx;
                            n_root_ok = c_idx_ok;
                        end
                        default: n_cop = COP_NONE;
                    endcase
                end
            end

            // Push the root if it is in range and live
            ST_ROOT: begin
                if (r_root_ok && r_live[r_n]) begin
                    n_mark[r_n] = 1'b1;
                    c_stk_we    = 1'b1;
                    c_stk_waddr = '0;
                    c_stk_wdata = r_n;
                    n_sp        = SPW'(1);
                end
            end

            // Pop the next node to expand, or start the sweep
            ST_POP: begin
                if (r_sp != '0) begin
                    c_stk_re = 1'b1;
                    n_sp     = c_sp_dec;
                end else begin
                    n_n = '0;
                end
            end

            // Fetch the popped node's edges
            ST_FETCH: begin
                c_edge_re    = 1'b1;
                c_edge_raddr = c_stk_rdata;
                n_slot       = '0;
            end

            // One edge slot per cycle: mark and push new live targets
            ST_SLOT: begin
                if (c_sel_pres && r_live[c_sel_tgt] && !r_mark[c_sel_tgt]) begin
                    n_mark[c_sel_tgt] = 1'b1;
                    c_stk_we          = 1'b1;
                    n_sp              = r_sp + SPW'(1);
                end
                n_slot = r_slot + 2'd1;
            end

            // Sweep: look at one node per cycle
            ST_SCAN: begin
                if (c_node_free) begin
                    c_edge_re = 1'b1;
                    c_val_re  = 1'b1;
                    n_slot    = '0;
                end else if (r_n != LAST_NODE) begin
                    n_n = r_n + IW'(1);
                end
            end

            // Decrement the count of each edge target
            ST_DEC: begin
                if (c_sel_pres) begin
                    n_cop   = COP_DEC;
                    n_caddr = c_sel_tgt;
                end
                n_slot = r_slot + 2'd1;
            end

            // Read the freed node's own count after its decrements
            ST_PEEK: begin
                n_cop   = COP_PEEK;
                n_caddr = r_n;
            end

            // Retire the held result and hold this one until the next is known
            ST_EMIT: begin
                if (c_emit_go) begin
                    if (r_pend_vld) begin
                        n_out     = r_pend;
                        n_out_vld = 1'b1;
                    end
                    n_pend.freed_valid = 1'b1;
                    n_pend.freed_index = c_n_x[2:0];
                    n_pend.freed_value = c_val_rdata;
                    n_pend.freed_count = c_cnt_x[7:0];
                    n_pend.last        = 1'b0;
                    n_pend_vld         = 1'b1;
                    n_live[r_n]        = 1'b0;
                    if (r_n != LAST_NODE) begin
                        n_n = r_n + IW'(1);
                    end
                end
            end

            // Closing beat of the collect
            ST_FIN: begin
                if (c_out_free) begin
                    if (r_pend_vld) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = RES_EMPTY;
                    end
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_mark     = '0;
                    n_sp       = '0;
                end
            end

            default: n_cop = COP_NONE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_live     <= '0;
            r_mark     <= '0;
            r_sp       <= '0;
            r_n        <= '0;
            r_root_ok  <= 1'b0;
            r_slot     <= '0;
            r_cop      <= COP_NONE;
            r_fwd_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_live     <= n_live;
            r_mark     <= n_mark;
            r_sp       <= n_sp;
            r_n        <= n_n;
            r_root_ok  <= n_root_ok;
            r_slot     <= n_slot;
            r_cop      <= n_cop;
            r_fwd_vld  <= c_cnt_we;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_caddr    <= n_caddr;
        r_fwd_addr <= r_caddr;
        r_fwd_data <= c_cnt_wdata;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    // Channel outputs
    assign i_cmd.ready       = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_vld;
    assign o_res.freed_valid = r_out.freed_valid;
    assign o_res.freed_index = r_out.freed_index;
    assign o_res.freed_value = r_out.freed_value;
    assign o_res.freed_count = r_out.freed_count;
    assign o_res.last        = r_out.last;

endmodule

`default_nettype wire

[rtl/msc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module msc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
